// File: rtl/core/pfr_pkg.sv
package pfr_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_MAX_GLYPH_WIDTH  = 16;
    localparam int DEF_MAX_GLYPH_HEIGHT = 16;
    localparam int DEF_CHAR_SLOTS       = 256;
    localparam int DEF_POSITION_BITS    = 16;

    // Stream and configuration port widths
    localparam int IN_DATA_BITS  = 40;
    localparam int IN_USER_BITS  = 3;
    localparam int OUT_DATA_BITS = 72;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 9;

    // Character code that advances by the space width
    localparam logic [7:0] SPACE_CODE = 8'h20;

    // Input item kinds
    typedef enum logic [2:0] {
        KIND_LOAD_WIDTH = 3'd0,
        KIND_LOAD_ROW   = 3'd1,
        KIND_START      = 3'd2,
        KIND_RENDER     = 3'd3,
        KIND_END        = 3'd4
    } kind_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_CHAR_COUNT   = 3'd0,
        REG_SPACE_WIDTH  = 3'd1,
        REG_GLYPH_HEIGHT = 3'd2,
        REG_MAX_WIDTH    = 3'd3,
        REG_FOREGROUND   = 3'd4
    } cfg_reg_t;

    // Pen advance selection
    typedef enum logic [1:0] {
        ADV_NONE  = 2'd0,
        ADV_SPACE = 2'd1,
        ADV_MAX   = 2'd2,
        ADV_GLYPH = 2'd3
    } adv_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       take;       // input transfer this cycle
        adv_t       adv;        // pen advance
        logic       rd_en;      // issue a glyph row read
        logic [3:0] rd_row;     // glyph row to read
        logic       out_seg;    // load output with the fetched row segment
        logic [3:0] out_row;    // image row of that segment
        logic       out_last;   // final row of the character
        logic       out_total;  // load output with the total width
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        kind_t      kind;       // kind of the offered input item
        logic       unknown;    // offered code has no glyph
        logic       space;      // offered code is the space code
        logic [4:0] rows;       // glyph rows to emit, clamped
        logic       out_free;   // output register can take a result
    } dp_status_t;

endpackage

// File: rtl/core/pfr_ctrl.sv
module pfr_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  pfr_pkg::dp_status_t    status,
    output pfr_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ROWS  = 3'b010,
        ST_TOTAL = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [4:0]  rows_reg, rows_next;
    logic [4:0]  issue_row_reg, issue_row_next;
    logic        pend_reg, pend_next;
    logic [3:0]  pend_row_reg, pend_row_next;
    logic        load;
    logic        issue;
    logic        last;

    // Sequence item acceptance and the row fetch / emit pipeline
    always_comb
    begin
        state_next     = state_reg;
        rows_next      = rows_reg;
        issue_row_next = issue_row_reg;
        pend_next      = pend_reg;
        pend_row_next  = pend_row_reg;
        cmd            = '0;
        cmd.adv        = pfr_pkg::ADV_NONE;
        s_tready       = 1'b0;
        load           = 1'b0;
        issue          = 1'b0;
        last           = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.take = 1'b1;
                    case (status.kind)
                        pfr_pkg::KIND_RENDER:
                        begin
                            if (status.unknown)
                            begin
                                cmd.adv = pfr_pkg::ADV_MAX;
                            end
                            else if (status.space)
                            begin
                                cmd.adv = pfr_pkg::ADV_SPACE;
                            end
                            else
                            begin
                                state_next     = ST_ROWS;
                                rows_next      = status.rows;
                                issue_row_next = 5'd0;
                                pend_next      = 1'b0;
                            end
                        end
                        pfr_pkg::KIND_END:
                        begin
                            state_next = ST_TOTAL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_ROWS:
            begin
                load  = pend_reg && status.out_free;
                last  = ((5'(pend_row_reg) + 5'd1) == rows_reg);
                issue = (issue_row_reg < rows_reg) && (!pend_reg || load);

                cmd.rd_en    = issue;
                cmd.rd_row   = issue_row_reg[3:0];
                cmd.out_seg  = load;
                cmd.out_row  = pend_row_reg;
                cmd.out_last = last;

                if (issue)
                begin
                    pend_next      = 1'b1;
                    pend_row_next  = issue_row_reg[3:0];
                    issue_row_next = issue_row_reg + 5'd1;
                end
                else if (load)
                begin
                    pend_next = 1'b0;
                end

                // Advance the pen once the last row is handed over, or at once when there are no rows
                if ((rows_reg == 5'd0) || (load && last))
                begin
                    cmd.adv    = pfr_pkg::ADV_GLYPH;
                    state_next = ST_IDLE;
                end
            end

            ST_TOTAL:
            begin
                if (status.out_free)
                begin
                    cmd.out_total = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rows_reg      <= 5'd0;
            issue_row_reg <= 5'd0;
            pend_reg      <= 1'b0;
            pend_row_reg  <= 4'd0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_reg      <= rows_next;
            issue_row_reg <= issue_row_next;
            pend_reg      <= pend_next;
            pend_row_reg  <= pend_row_next;
        end
    end

endmodule

// File: rtl/core/pfr_datapath.sv
module pfr_datapath
#(
    parameter int MAX_GLYPH_WIDTH  = pfr_pkg::DEF_MAX_GLYPH_WIDTH,
    parameter int MAX_GLYPH_HEIGHT = pfr_pkg::DEF_MAX_GLYPH_HEIGHT,
    parameter int CHAR_SLOTS       = pfr_pkg::DEF_CHAR_SLOTS,
    parameter int POSITION_BITS    = pfr_pkg::DEF_POSITION_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [pfr_pkg::IN_DATA_BITS-1:0]    s_tdata,
    input  logic [pfr_pkg::IN_USER_BITS-1:0]    s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pfr_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    output logic                                m_tuser,
    output logic                                m_tlast,
    input  logic                                cfg_wr_en,
    input  logic [pfr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [pfr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  pfr_pkg::ctrl_cmd_t                  cmd,
    output pfr_pkg::dp_status_t                 status
);

    localparam int CODE_BITS   = (CHAR_SLOTS > 1) ? $clog2(CHAR_SLOTS) : 1;
    localparam int ROW_BITS    = (MAX_GLYPH_HEIGHT > 1) ? $clog2(MAX_GLYPH_HEIGHT) : 1;
    localparam int GLYPH_DEPTH = CHAR_SLOTS * (1 << ROW_BITS);
    localparam int WIDTH_CAP   = (MAX_GLYPH_WIDTH < 16) ? MAX_GLYPH_WIDTH : 16;
    localparam int HEIGHT_CAP  = (MAX_GLYPH_HEIGHT < 16) ? MAX_GLYPH_HEIGHT : 16;

    // Unpacked input fields
    pfr_pkg::kind_t  in_kind;
    logic [7:0]      in_code;
    logic [3:0]      in_row;
    logic [15:0]     in_pixels;
    logic [4:0]      in_width;
    logic [4:0]      in_width_clamped;
    logic            in_code_ok;
    logic            in_row_ok;
    logic [CODE_BITS-1:0] in_code_idx;

    // Configuration registers
    logic [8:0] char_count_reg;
    logic [4:0] space_width_reg;
    logic [4:0] glyph_height_reg;
    logic [4:0] max_width_reg;
    logic [7:0] foreground_reg;

    // Width table and glyph row store
    logic [4:0]            width_mem [CHAR_SLOTS];
    logic [CHAR_SLOTS-1:0] wt_valid_reg;
    logic [4:0]            wt_rd_reg;
    logic                  wt_vld_reg;
    logic [15:0]           glyph_mem [GLYPH_DEPTH];
    logic [15:0]           glyph_rd_reg;
    logic [CODE_BITS-1:0]  code_reg;

    // Pen and output register
    logic [POSITION_BITS-1:0] pen_reg, pen_next;
    logic [POSITION_BITS:0]   pen_sum;
    logic [4:0]               adv_amount;
    logic [4:0]               glyph_w;
    logic [15:0]              seg_mask;
    logic                     m_tvalid_reg;
    logic [pfr_pkg::OUT_DATA_BITS-1:0] m_tdata_reg;
    logic                     m_tuser_reg;
    logic                     m_tlast_reg;
    logic                     out_free;

    // Input field layout, lowest bits first
    always_comb
    begin
        in_kind     = pfr_pkg::kind_t'(s_tuser[2:0]);
        in_code     = s_tdata[7:0];
        in_row      = s_tdata[11:8];
        in_pixels   = s_tdata[27:12];
        in_width    = s_tdata[32:28];
        in_code_ok  = ({1'b0, in_code} < 9'(CHAR_SLOTS));
        in_row_ok   = (32'(in_row) < MAX_GLYPH_HEIGHT);
        in_code_idx = CODE_BITS'(in_code);
        in_width_clamped = (in_width > 5'(WIDTH_CAP)) ? 5'(WIDTH_CAP) : in_width;
    end

    // Status toward the controller
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        status.kind     = in_kind;
        status.unknown  = ({1'b0, in_code} >= char_count_reg) || !in_code_ok;
        status.space    = (in_code == pfr_pkg::SPACE_CODE);
        status.rows     = (glyph_height_reg > 5'(HEIGHT_CAP)) ? 5'(HEIGHT_CAP)
                                                              : glyph_height_reg;
        status.out_free = out_free;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_count_reg   <= 9'd0;
            space_width_reg  <= 5'd0;
            glyph_height_reg <= 5'd0;
            max_width_reg    <= 5'd0;
            foreground_reg   <= 8'd0;
        end
        else if (cfg_wr_en)
        begin
            case (pfr_pkg::cfg_reg_t'(cfg_index))
                pfr_pkg::REG_CHAR_COUNT:   char_count_reg   <= cfg_data;
                pfr_pkg::REG_SPACE_WIDTH:  space_width_reg  <= cfg_data[4:0];
                pfr_pkg::REG_GLYPH_HEIGHT: glyph_height_reg <= cfg_data[4:0];
                pfr_pkg::REG_MAX_WIDTH:    max_width_reg    <= cfg_data[4:0];
                pfr_pkg::REG_FOREGROUND:   foreground_reg   <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Width table: memory plus per-entry valid bits cleared at reset
    always_ff @(posedge clk)
    begin
        if (cmd.take && (in_kind == pfr_pkg::KIND_LOAD_WIDTH) && in_code_ok)
        begin
            width_mem[in_code_idx] <= in_width_clamped;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wt_valid_reg <= '0;
        end
        else if (cmd.take && (in_kind == pfr_pkg::KIND_LOAD_WIDTH) && in_code_ok)
        begin
            wt_valid_reg[in_code_idx] <= 1'b1;
        end
    end

    // Look up the width and hold the code while an item is taken
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            wt_rd_reg  <= width_mem[in_code_idx];
            wt_vld_reg <= wt_valid_reg[in_code_idx];
            code_reg   <= in_code_idx;
        end
    end

    assign glyph_w  = wt_vld_reg ? wt_rd_reg : 5'd0;
    assign seg_mask = ~(16'hFFFF << glyph_w);

    // Glyph row store
    always_ff @(posedge clk)
    begin
        if (cmd.take && (in_kind == pfr_pkg::KIND_LOAD_ROW) && in_code_ok && in_row_ok)
        begin
            glyph_mem[{in_code_idx, ROW_BITS'(in_row)}] <= in_pixels;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            glyph_rd_reg <= glyph_mem[{code_reg, ROW_BITS'(cmd.rd_row)}];
        end
    end

    // Pen: clear on start, saturating advance
    always_comb
    begin
        case (cmd.adv)
            pfr_pkg::ADV_SPACE: adv_amount = space_width_reg;
            pfr_pkg::ADV_MAX:   adv_amount = max_width_reg;
            pfr_pkg::ADV_GLYPH: adv_amount = glyph_w;
            default:            adv_amount = 5'd0;
        endcase
        pen_sum = {1'b0, pen_reg} + (POSITION_BITS + 1)'(adv_amount);
        if (cmd.take && (in_kind == pfr_pkg::KIND_START))
        begin
            pen_next = '0;
        end
        else if (pen_sum[POSITION_BITS])
        begin
            pen_next = '1;
        end
        else
        begin
            pen_next = pen_sum[POSITION_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_reg <= '0;
        end
        else
        begin
            pen_reg <= pen_next;
        end
    end

    // Output register: hold until transfer, load segment or total
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_seg || cmd.out_total)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_seg)
        begin
            m_tdata_reg <= {7'd0, 16'd0, foreground_reg, glyph_w,
                            glyph_rd_reg & seg_mask, 16'(pen_reg), cmd.out_row};
            m_tuser_reg <= 1'b0;
            m_tlast_reg <= cmd.out_last;
        end
        else if (cmd.out_total)
        begin
            m_tdata_reg <= {7'd0, 16'(pen_reg), 8'd0, 5'd0, 16'd0, 16'd0, 4'd0};
            m_tuser_reg <= 1'b1;
            m_tlast_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// File: rtl/core/proportional_font_row_renderer_top.sv
// Load, start and pen-only render items (space, unknown code) complete as they are taken.
// A glyph render's first row passes the state register and the row read register
// before it reaches the output register, then one row per cycle while the output is
// free, paced by the single glyph store read port. End items wait for a free output.
// Reset (rst_n, async, active low) clears configuration, pen and width table valid
// bits; the glyph row store is not cleared and needs no clearing pass.
module proportional_font_row_renderer_top
#(
    parameter int MAX_GLYPH_WIDTH  = pfr_pkg::DEF_MAX_GLYPH_WIDTH,
    parameter int MAX_GLYPH_HEIGHT = pfr_pkg::DEF_MAX_GLYPH_HEIGHT,
    parameter int CHAR_SLOTS       = pfr_pkg::DEF_CHAR_SLOTS,
    parameter int POSITION_BITS    = pfr_pkg::DEF_POSITION_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // char_code[7:0], row_number[11:8], row_pixels[27:12], glyph_width[32:28], zero pad
    input  logic [pfr_pkg::IN_DATA_BITS-1:0]    s_tdata,
    // kind[2:0]
    input  logic [pfr_pkg::IN_USER_BITS-1:0]    s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // image_row[3:0], start_column[19:4], segment_pixels[35:20], segment_width[40:36],
    // color_index[48:41], total_width[64:49], zero pad
    output logic [pfr_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    // is_total[0]
    output logic                                m_tuser,
    // last_of_char
    output logic                                m_tlast,
    input  logic                                cfg_wr_en,
    input  logic [pfr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [pfr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    pfr_pkg::ctrl_cmd_t  cmd;
    pfr_pkg::dp_status_t status;

    // Sequencer
    pfr_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Tables, pen and output register
    pfr_datapath
    #(
        .MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
        .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT),
        .CHAR_SLOTS       (CHAR_SLOTS),
        .POSITION_BITS    (POSITION_BITS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
